// ===== src/dpts_pkg.sv =====
// ----------------------------------------------------------------------------
// dpts_pkg
// Shared types and codes for the dual position trigger sequencer.
// ----------------------------------------------------------------------------
package dpts_pkg;

  // Operation codes carried with each input item.
  localparam logic [2:0] OP_POSITION = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_ROW_UP   = 3'd3;
  localparam logic [2:0] OP_ROW_DOWN = 3'd4;

  // Response codes.
  localparam logic [3:0] RSP_NONE       = 4'd0;
  localparam logic [3:0] RSP_START_OK   = 4'd1;
  localparam logic [3:0] RSP_START_REF  = 4'd2;
  localparam logic [3:0] RSP_STOP_ACK   = 4'd3;
  localparam logic [3:0] RSP_READY_UP   = 4'd4;
  localparam logic [3:0] RSP_UP_ACK     = 4'd5;
  localparam logic [3:0] RSP_READY_DOWN = 4'd6;
  localparam logic [3:0] RSP_DOWN_ACK   = 4'd7;
  localparam logic [3:0] RSP_COMPLETE   = 4'd8;
  localparam logic [3:0] RSP_FATAL      = 4'd9;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_STEP   = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_TPR    = 3'd2;
  localparam logic [2:0] REG_ROWS   = 3'd3;
  localparam logic [2:0] REG_MODE   = 3'd4;
  localparam logic [2:0] REG_SEP    = 3'd5;

  localparam int MAX_RESULTS = 4;
  localparam int QDEPTH      = 4;

  typedef struct packed {
    logic [31:0]        step;
    logic [31:0]        offset;
    logic [12:0]        tpr;
    logic [12:0]        rows;
    logic [1:0]         mode;
    logic signed [31:0] sep;
  } dpts_cfg_t;

  // All results caused by one input item.
  typedef struct packed {
    logic            trig_first;
    logic            trig_second;
    logic [1:0]      last_idx;
    logic [3:0][3:0] code;
    logic [3:0]      scan;
  } dpts_bundle_t;

endpackage

// ===== src/dpts_front.sv =====
// ----------------------------------------------------------------------------
// dpts_front
// Accepts items, runs the scan state machine on one item per cycle while the
// queue has room and no step write waits, and pushes a result bundle per item.
// ----------------------------------------------------------------------------
module dpts_front #(
  parameter int MAX_TRIGGERS  = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpts_pkg::dpts_cfg_t   cfg,
  input  logic                  step_wr,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            op,
  input  logic signed [31:0]    pos,
  input  logic                  q_full,
  output logic                  push,
  output dpts_pkg::dpts_bundle_t bundle
);

  localparam int IDX_W = $clog2(MAX_TRIGGERS);
  localparam int M_W   = IDX_W + 32;
  localparam int SUM_W = IDX_W + 33;
  localparam int CMP_W = SUM_W + 1;
  localparam int EW    = (IDX_W + 1 > 13) ? IDX_W + 2 : 14;
  localparam logic [SUM_W-1:0] ADDC =
    SUM_W'((64'd10 << FRACTION_BITS) + ((64'd1 << FRACTION_BITS) >> 1));
  localparam logic [EW-1:0] MAXT = EW'(MAX_TRIGGERS);

  logic                    scan_r, down_r, stale_r;
  logic [IDX_W-1:0]        idx_r   [2];
  logic [M_W-1:0]          m_r     [2];
  logic signed [CMP_W-1:0] bp_r    [2];
  logic [3:0]              pass_r;
  logic [1:0]              wait_r;
  logic [12:0]             lap_r;

  logic                    scan_nxt, down_nxt;
  logic [IDX_W-1:0]        idx_nxt [2];
  logic [M_W-1:0]          m_nxt   [2];
  logic signed [CMP_W-1:0] bp_nxt  [2];
  logic [3:0]              pass_nxt;
  logic [1:0]              wait_nxt;
  logic [12:0]             lap_nxt;

  logic [M_W-1:0]          m_inc   [2];
  logic [M_W-1:0]          m_dec   [2];
  logic signed [CMP_W-1:0] bp_inc  [2];
  logic signed [CMP_W-1:0] bp_dec  [2];
  logic signed [CMP_W-1:0] bp_same [2];
  logic signed [CMP_W-1:0] bp_zero;
  logic signed [CMP_W-1:0] p_cmp   [2];
  logic signed [EW-1:0]    last_s;
  logic                    accept;

  function automatic logic signed [CMP_W-1:0] round_bp(input logic [M_W-1:0] m,
                                                       input logic [31:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(m) + SUM_W'(off) + ADDC;
    return signed'(CMP_W'(sum >> FRACTION_BITS));
  endfunction

  always_comb begin
    logic [EW-1:0] eff;
    eff = (EW'(cfg.tpr) > MAXT) ? MAXT : EW'(cfg.tpr);
    last_s = signed'(eff - EW'(1));
    for (int c = 0; c < 2; c++) begin
      m_inc[c]   = m_r[c] + M_W'(cfg.step);
      m_dec[c]   = m_r[c] - M_W'(cfg.step);
      bp_inc[c]  = round_bp(m_inc[c], cfg.offset);
      bp_dec[c]  = round_bp(m_dec[c], cfg.offset);
      bp_same[c] = round_bp(m_r[c], cfg.offset);
    end
    bp_zero  = round_bp('0, cfg.offset);
    p_cmp[0] = CMP_W'(pos);
    p_cmp[1] = CMP_W'(33'(pos) - 33'(cfg.sep));
  end

  assign in_ready = !q_full && !stale_r;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  always_comb begin
    logic [2:0]              n;
    logic                    done, stop, oth, up, dn, oup;
    logic [1:0]              en;
    logic signed [CMP_W-1:0] cand;
    logic signed [EW-1:0]    idx_s;

    scan_nxt = scan_r;
    down_nxt = down_r;
    idx_nxt  = idx_r;
    m_nxt    = m_r;
    bp_nxt   = bp_r;
    pass_nxt = pass_r;
    wait_nxt = wait_r;
    lap_nxt  = lap_r;
    bundle   = '0;
    n        = '0;
    done     = 1'b0;
    en       = cfg.mode;
    stop     = 1'b0;
    oth      = 1'b0;
    up       = 1'b0;
    dn       = 1'b0;
    oup      = 1'b0;
    cand     = '0;
    idx_s    = '0;

    unique case (op) inside
      dpts_pkg::OP_START: begin
        if (scan_r) begin
          bundle.code[0] = dpts_pkg::RSP_START_REF;
          bundle.scan[0] = 1'b1;
          n = 3'd1;
        end else begin
          scan_nxt = 1'b1;
          down_nxt = 1'b0;
          idx_nxt  = '{default: '0};
          m_nxt    = '{default: '0};
          pass_nxt = '0;
          wait_nxt = '0;
          lap_nxt  = '0;
          bp_nxt   = '{default: bp_zero};
          bundle.code[0] = dpts_pkg::RSP_START_OK;
          bundle.scan[0] = 1'b1;
          n = 3'd1;
          // Every breakpoint is at least ten, so position zero never lies past
          // it; only the second channel's shifted position can be past its
          // start point.
          if (en[1] && (-CMP_W'(cfg.sep) > bp_zero)) begin
            scan_nxt = 1'b0;
            bundle.code[1] = dpts_pkg::RSP_FATAL;
            bundle.scan[1] = 1'b0;
            n = 3'd2;
          end
        end
      end
      dpts_pkg::OP_STOP: begin
        scan_nxt = 1'b0;
        bundle.code[0] = dpts_pkg::RSP_STOP_ACK;
        n = 3'd1;
      end
      dpts_pkg::OP_ROW_UP, dpts_pkg::OP_ROW_DOWN: begin
        if (scan_r) begin
          wait_nxt = '0;
          down_nxt = (op == dpts_pkg::OP_ROW_UP);
        end
        bundle.code[0] = (op == dpts_pkg::OP_ROW_UP) ? dpts_pkg::RSP_UP_ACK
                                                      : dpts_pkg::RSP_DOWN_ACK;
        bundle.scan[0] = scan_r;
        n = 3'd1;
      end
      dpts_pkg::OP_POSITION: begin
        if (scan_r && pos < 0) begin
          scan_nxt = 1'b0;
          bundle.code[0] = dpts_pkg::RSP_FATAL;
          n = 3'd1;
        end else if (scan_r) begin
          for (int c = 0; c < 2; c++) begin
            oth   = en[1-c];
            stop  = 1'b0;
            cand  = bp_same[c];
            idx_s = signed'(EW'(idx_nxt[c]));
            if (en[c] && !done && !wait_nxt[c]) begin
              if (p_cmp[c] != bp_nxt[c]) begin
                if (down_nxt ? (p_cmp[c] < bp_nxt[c]) : (p_cmp[c] > bp_nxt[c]))
                  stop = 1'b1;
                if (stop) begin
                  scan_nxt = 1'b0;
                  if (n < 3'd4) begin
                    bundle.code[n[1:0]] = dpts_pkg::RSP_FATAL;
                    bundle.scan[n[1:0]] = 1'b0;
                    n = n + 3'd1;
                  end
                end
                done = stop;
              end else begin
                if (c == 0) bundle.trig_first  = 1'b1;
                else        bundle.trig_second = 1'b1;
                oup = pass_nxt[2*(1-c)];
                if (!down_nxt) begin
                  if (idx_s == last_s) begin
                    if (c == 1 && oth && !oup) begin
                      stop = 1'b1;
                    end else begin
                      pass_nxt[2*c] = 1'b1;
                      if ((c == 1 || !oth) && n < 3'd4) begin
                        bundle.code[n[1:0]] = dpts_pkg::RSP_READY_UP;
                        bundle.scan[n[1:0]] = scan_nxt;
                        n = n + 3'd1;
                      end
                      wait_nxt[c] = 1'b1;
                    end
                  end else if (idx_s < last_s) begin
                    idx_nxt[c] = idx_nxt[c] + IDX_W'(1);
                    m_nxt[c]   = m_inc[c];
                    cand       = bp_inc[c];
                  end else begin
                    stop = 1'b1;
                  end
                end else begin
                  if (!pass_nxt[2*c] || (oth && !oup)) begin
                    stop = 1'b1;
                  end else if (idx_nxt[c] == '0) begin
                    if (c == 0 && oth && !pass_nxt[3]) begin
                      stop = 1'b1;
                    end else begin
                      pass_nxt[2*c+1] = 1'b1;
                      if ((c == 0 || !oth) && n < 3'd4) begin
                        bundle.code[n[1:0]] = dpts_pkg::RSP_READY_DOWN;
                        bundle.scan[n[1:0]] = scan_nxt;
                        n = n + 3'd1;
                      end
                      wait_nxt[c] = 1'b1;
                    end
                  end else begin
                    idx_nxt[c] = idx_nxt[c] - IDX_W'(1);
                    m_nxt[c]   = m_dec[c];
                    cand       = bp_dec[c];
                  end
                end
                up = pass_nxt[2*c];
                dn = pass_nxt[2*c+1];
                // A finished up-and-down pass closes one lap.
                if (!stop && up && dn && (c == 0 || !oth)) begin
                  if (c == 0 && oth && pass_nxt[3:2] != 2'b11) begin
                    stop = 1'b1;
                  end else begin
                    if (c == 0 && oth) pass_nxt = '0;
                    else begin
                      pass_nxt[2*c]   = 1'b0;
                      pass_nxt[2*c+1] = 1'b0;
                    end
                    lap_nxt = lap_nxt + 13'd1;
                    if ({lap_nxt, 1'b0} >= {1'b0, cfg.rows}) begin
                      scan_nxt = 1'b0;
                      if (n < 3'd4) begin
                        bundle.code[n[1:0]] = dpts_pkg::RSP_COMPLETE;
                        bundle.scan[n[1:0]] = 1'b0;
                        n = n + 3'd1;
                      end
                      done = 1'b1;
                    end
                  end
                end
                if (!stop && !done) begin
                  bp_nxt[c] = cand;
                  if (down_nxt ? (p_cmp[c] < cand) : (p_cmp[c] > cand)) stop = 1'b1;
                end
                if (stop) begin
                  scan_nxt = 1'b0;
                  if (n < 3'd4) begin
                    bundle.code[n[1:0]] = dpts_pkg::RSP_FATAL;
                    bundle.scan[n[1:0]] = 1'b0;
                    n = n + 3'd1;
                  end
                  done = 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (n == '0) begin
      bundle.code[0] = dpts_pkg::RSP_NONE;
      bundle.scan[0] = scan_nxt;
      n = 3'd1;
    end
    bundle.last_idx = 2'(n - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= 1'b0;
      down_r  <= 1'b0;
      stale_r <= 1'b0;
      idx_r   <= '{default: '0};
      m_r     <= '{default: '0};
      bp_r    <= '{default: '0};
      pass_r  <= '0;
      wait_r  <= '0;
      lap_r   <= '0;
    end else begin
      if (accept) begin
        scan_r <= scan_nxt;
        down_r <= down_nxt;
        idx_r  <= idx_nxt;
        m_r    <= m_nxt;
        bp_r   <= bp_nxt;
        pass_r <= pass_nxt;
        wait_r <= wait_nxt;
        lap_r  <= lap_nxt;
      end else if (stale_r) begin
        // New step size: rebuild the running index*step products.
        for (int c = 0; c < 2; c++) m_r[c] <= M_W'(idx_r[c]) * M_W'(cfg.step);
      end
      stale_r <= step_wr;
    end
  end

endmodule

// ===== src/dpts_queue.sv =====
// ----------------------------------------------------------------------------
// dpts_queue
// Short queue of result bundles between the front and the back part.
// ----------------------------------------------------------------------------
module dpts_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  dpts_pkg::dpts_bundle_t wdata,
  output logic                   full,
  input  logic                   pop,
  output logic                   valid,
  output dpts_pkg::dpts_bundle_t rdata
);

  localparam int PW = $clog2(dpts_pkg::QDEPTH);

  dpts_pkg::dpts_bundle_t mem_r [dpts_pkg::QDEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(dpts_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PW'(1);
      if (pop)  rd_r <= rd_r + PW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dpts_back.sv =====
// ----------------------------------------------------------------------------
// dpts_back
// Takes queued bundles; sends one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module dpts_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  dpts_pkg::dpts_bundle_t q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_data,
  output logic                   out_last
);

  dpts_pkg::dpts_bundle_t cur_r;
  logic                   have_r;
  logic [1:0]             pos_r;
  logic                   first;

  assign out_valid = have_r;
  assign out_last  = (pos_r == cur_r.last_idx);
  assign first     = (pos_r == 2'd0);
  assign pop       = q_valid && (!have_r || (out_ready && out_last));
  assign out_data  = {1'b0, cur_r.scan[pos_r], cur_r.code[pos_r],
                      cur_r.trig_second && first, cur_r.trig_first && first};

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      pos_r  <= '0;
    end else if (pop) begin
      have_r <= 1'b1;
      pos_r  <= '0;
    end else if (have_r && out_ready) begin
      if (out_last) have_r <= 1'b0;
      else          pos_r  <= pos_r + 2'd1;
    end
  end

endmodule

// ===== src/dual_position_trigger_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// dual_position_trigger_sequencer_core
// Position-driven trigger sequencer for one or two channels with a register
// port, an item input stream and a result stream.
// ----------------------------------------------------------------------------
// Usage: the input stream carries position samples and host commands; the
// operation code travels in in_tuser and the signed position in in_tdata.
// Every accepted item produces one to four result items on the output stream,
// the last one flagged by out_tlast. Trigger bits appear only on the first
// result of an item. The user must write registers through the APB-style port
// only while the block is idle, which the block does not enforce. A write to
// the step register blocks input while the per-channel index*step products
// are rebuilt by the multiplier. Throughput: one input item per cycle while
// each item yields a single result and no step write blocks input; an item
// with several results holds the output until all are sent. Results pass
// through the queue and then the output register. The front evaluates each
// item combinationally, its speed set by the breakpoint adder and compares
// per channel. Reset clears the scan state, the queue and the output;
// registers return to their reset values. On a receiver stall, results wait
// in the output register and a four-entry queue; input stalls when it fills.
module dual_position_trigger_sequencer_core #(
  parameter int MAX_TRIGGERS  = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: in_tdata = position[31:0]; in_tuser = operation[2:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  // Output stream: out_tdata = trigger_first[0], trigger_second[1],
  // response[5:2], scanning[6], zero pad[7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // Register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dpts_pkg::dpts_cfg_t    cfg_r;
  dpts_pkg::dpts_bundle_t f_bundle, q_data;
  logic                   wr_en, step_wr, push, q_full, q_valid, pop;
  logic [2:0]             reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign step_wr    = wr_en && (reg_idx == dpts_pkg::REG_STEP);

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step   <= 32'd65536;
      cfg_r.offset <= '0;
      cfg_r.tpr    <= 13'd1;
      cfg_r.rows   <= 13'd1;
      cfg_r.mode   <= 2'd1;
      cfg_r.sep    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        dpts_pkg::REG_STEP:   cfg_r.step   <= cfg_pwdata;
        dpts_pkg::REG_OFFSET: cfg_r.offset <= cfg_pwdata;
        dpts_pkg::REG_TPR:    cfg_r.tpr    <= cfg_pwdata[12:0];
        dpts_pkg::REG_ROWS:   cfg_r.rows   <= cfg_pwdata[12:0];
        dpts_pkg::REG_MODE:   cfg_r.mode   <= cfg_pwdata[1:0];
        dpts_pkg::REG_SEP:    cfg_r.sep    <= signed'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dpts_pkg::REG_STEP:   cfg_prdata = cfg_r.step;
      dpts_pkg::REG_OFFSET: cfg_prdata = cfg_r.offset;
      dpts_pkg::REG_TPR:    cfg_prdata = 32'(cfg_r.tpr);
      dpts_pkg::REG_ROWS:   cfg_prdata = 32'(cfg_r.rows);
      dpts_pkg::REG_MODE:   cfg_prdata = 32'(cfg_r.mode);
      dpts_pkg::REG_SEP:    cfg_prdata = cfg_r.sep;
      default:              cfg_prdata = '0;
    endcase
  end

  dpts_front #(
    .MAX_TRIGGERS (MAX_TRIGGERS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step_wr (step_wr),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .op      (in_tuser),
    .pos     (signed'(in_tdata)),
    .q_full  (q_full),
    .push    (push),
    .bundle  (f_bundle)
  );

  dpts_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(f_bundle),
    .full (q_full),
    .pop  (pop),
    .valid(q_valid),
    .rdata(q_data)
  );

  dpts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata),
    .out_last (out_tlast)
  );

endmodule

// ===== src/dpts_checker.sv =====
// ----------------------------------------------------------------------------
// dpts_checker
// Port-level checks on the sequencer's result stream.
// ----------------------------------------------------------------------------
module dpts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A pending result is not withdrawn.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered after reset");

  // Response codes stay within the defined set.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:2] <= dpts_pkg::RSP_FATAL)
    else $error("undefined response code");

  // Triggers come only from position samples, never with a command ack.
  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[1]) |->
      (out_tdata[5:2] == dpts_pkg::RSP_NONE ||
       out_tdata[5:2] == dpts_pkg::RSP_READY_UP ||
       out_tdata[5:2] == dpts_pkg::RSP_READY_DOWN ||
       out_tdata[5:2] == dpts_pkg::RSP_COMPLETE ||
       out_tdata[5:2] == dpts_pkg::RSP_FATAL))
    else $error("trigger on a command result");

endmodule

bind dual_position_trigger_sequencer_core dpts_checker u_dpts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
